// ===== design/mmb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the min/max bag.
package mmb_pkg;

  localparam int DefCapacity   = 1024;
  localparam int DefValueWidth = 32;

  localparam int OpWidth     = 2;
  localparam int FieldWidth  = 32;

  typedef enum logic [OpWidth-1:0] {
    OpAdd       = 2'd0,
    OpRemoveMax = 2'd1,
    OpRemoveMin = 2'd2
  } op_e;

endpackage

// ===== design/mmb_in_if.sv =====
`timescale 1ns / 1ps
// Input channel of the min/max bag: operation and value.
interface mmb_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [mmb_pkg::OpWidth-1:0]    operation;
  logic signed [mmb_pkg::FieldWidth-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

// ===== design/mmb_out_if.sv =====
`timescale 1ns / 1ps
// Output channel of the min/max bag: removed value and status flags.
interface mmb_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [mmb_pkg::FieldWidth-1:0] result_value;
  logic                                  was_empty;
  logic                                  add_dropped;

  modport source (output valid, output result_value, output was_empty,
                  output add_dropped, input ready);
  modport sink   (input valid, input result_value, input was_empty,
                  input add_dropped, output ready);
endinterface

// ===== design/mmb_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module mmb_ram #(
  parameter int Width = mmb_pkg::DefValueWidth,
  parameter int Depth = mmb_pkg::DefCapacity,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/min_max_bag_unit.sv =====
`timescale 1ns / 1ps
// Top level of the min/max bag: unsorted store with max/min removal by scan.
//
//   channel | dir | payload                                  | handshake
//   --------+-----+------------------------------------------+-------------
//   in_i    | in  | operation[1:0], value[31:0]              | valid/ready
//   out_o   | out | result_value[31:0], was_empty, add_dropped | valid/ready
//
// Add, empty remove and unused codes finish in the accept cycle when the output is free.
// A remove on n stored entries makes one RAM read per cycle over entries
// 0..n-1, then writes the last entry into the hole once the result can leave.
// Reset clears the control state and the count, not the RAM; RAM contents are never read before written.
// A result that cannot leave sits in a holding register; input is refused
// until it goes out.
module min_max_bag_unit #(
  parameter int CAPACITY    = mmb_pkg::DefCapacity,
  parameter int VALUE_WIDTH = mmb_pkg::DefValueWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mmb_in_if.sink           in_i,
  mmb_out_if.source        out_o
);

  localparam int AddrW = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int ResW  = mmb_pkg::FieldWidth;
  localparam int VW    = VALUE_WIDTH;
  localparam int MinW  = (VW < ResW) ? VW : ResW;
  localparam logic [ResW-1:0] EmptyVal = {ResW{1'b1}} >> (ResW - MinW);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [AddrW-1:0]      scan_idx_q, scan_idx_d;
  logic [AddrW-1:0]      best_idx_q, best_idx_d;
  logic signed [VW-1:0]  best_q, best_d;
  logic [VW-1:0]         last_q, last_d;
  logic                  want_max_q, want_max_d;
  logic                  res_remove_q, res_remove_d;
  logic [ResW-1:0]       res_value_q, res_value_d;
  logic                  res_empty_q, res_empty_d;
  logic                  res_dropped_q, res_dropped_d;
  logic                  out_valid_q, out_valid_d;
  logic [ResW-1:0]       out_value_q, out_value_d;
  logic                  out_empty_q, out_empty_d;
  logic                  out_dropped_q, out_dropped_d;

  logic                  in_fire, out_free, better;
  logic [AddrW-1:0]      last_idx;
  logic                  ram_we;
  logic [AddrW-1:0]      ram_waddr, ram_raddr;
  logic [VW-1:0]         ram_wdata, ram_rdata;
  logic signed [VW-1:0]  rd_val;

  // Immediate result of the item in the accept cycle
  logic                  imm_valid;
  logic [ResW-1:0]       imm_value;
  logic                  imm_empty, imm_dropped;

  mmb_ram #(
    .Width (VW),
    .Depth (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_i.ready = (state_q == StIdle);
  assign in_fire    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  assign rd_val   = ram_rdata;
  assign last_idx = AddrW'(count_q - CntW'(1));
  // Strict compare keeps the lowest index on ties
  assign better   = (scan_idx_q == '0) ||
                    (want_max_q ? (rd_val > best_q) : (rd_val < best_q));

  // Entry 0 is fetched in the accept cycle, then one ahead of the data
  assign ram_raddr = (state_q == StIdle) ? '0 : scan_idx_q + AddrW'(1);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    scan_idx_d    = scan_idx_q;
    best_idx_d    = best_idx_q;
    best_d        = best_q;
    last_d        = last_q;
    want_max_d    = want_max_q;
    res_remove_d  = res_remove_q;
    res_value_d   = res_value_q;
    res_empty_d   = res_empty_q;
    res_dropped_d = res_dropped_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_value_d   = out_value_q;
    out_empty_d   = out_empty_q;
    out_dropped_d = out_dropped_q;
    ram_we        = 1'b0;
    ram_waddr     = AddrW'(count_q);
    ram_wdata     = VW'(in_i.value);
    imm_valid     = 1'b0;
    imm_value     = '0;
    imm_empty     = 1'b0;
    imm_dropped   = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          unique case (in_i.operation)
            mmb_pkg::OpAdd: begin
              imm_valid = 1'b1;
              if (count_q < CntW'(CAPACITY)) begin
                ram_we  = 1'b1;
                count_d = count_q + CntW'(1);
              end else begin
                imm_dropped = 1'b1;
              end
            end
            mmb_pkg::OpRemoveMax, mmb_pkg::OpRemoveMin: begin
              if (count_q == '0) begin
                imm_valid = 1'b1;
                imm_value = EmptyVal;
                imm_empty = 1'b1;
              end else begin
                state_d    = StScan;
                scan_idx_d = '0;
                want_max_d = (in_i.operation == mmb_pkg::OpRemoveMax);
              end
            end
            default: begin
              imm_valid = 1'b1;
            end
          endcase
          if (imm_valid) begin
            if (out_free) begin
              out_valid_d   = 1'b1;
              out_value_d   = imm_value;
              out_empty_d   = imm_empty;
              out_dropped_d = imm_dropped;
            end else begin
              state_d       = StFin;
              res_remove_d  = 1'b0;
              res_value_d   = imm_value;
              res_empty_d   = imm_empty;
              res_dropped_d = imm_dropped;
            end
          end
        end
      end
      StScan: begin
        if (better) begin
          best_d     = rd_val;
          best_idx_d = scan_idx_q;
        end
        scan_idx_d = scan_idx_q + AddrW'(1);
        if (scan_idx_q == last_idx) begin
          last_d        = ram_rdata;
          state_d       = StFin;
          res_remove_d  = 1'b1;
          res_empty_d   = 1'b0;
          res_dropped_d = 1'b0;
        end
      end
      StFin: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_value_d   = res_remove_q ? ResW'(best_q) : res_value_q;
          out_empty_d   = res_empty_q;
          out_dropped_d = res_dropped_q;
          state_d       = StIdle;
          if (res_remove_q) begin
            // Last entry fills the hole left by the removed one
            ram_we    = 1'b1;
            ram_waddr = best_idx_q;
            ram_wdata = last_q;
            count_d   = count_q - CntW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      count_q      <= '0;
      scan_idx_q   <= '0;
      want_max_q   <= 1'b0;
      res_remove_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      scan_idx_q   <= scan_idx_d;
      want_max_q   <= want_max_d;
      res_remove_q <= res_remove_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q    <= best_idx_d;
    best_q        <= best_d;
    last_q        <= last_d;
    res_value_q   <= res_value_d;
    res_empty_q   <= res_empty_d;
    res_dropped_q <= res_dropped_d;
    out_value_q   <= out_value_d;
    out_empty_q   <= out_empty_d;
    out_dropped_q <= out_dropped_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_value_q;
  assign out_o.was_empty    = out_empty_q;
  assign out_o.add_dropped  = out_dropped_q;

  // Count never passes the capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // Scan stays inside the stored entries
  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StScan) |-> (CntW'(scan_idx_q) < count_q))
    else $error("scan index beyond stored entries");

  // Empty and dropped flags exclude each other; empty carries the all-ones value
  a_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!(out_empty_q && out_dropped_q) &&
                     (!out_empty_q || (out_value_q == EmptyVal))))
    else $error("inconsistent result flags");

  // A remove of a non-empty store leaves the count one lower
  a_remove_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StFin) && res_remove_q && out_free) |=>
      (count_q == $past(count_q) - CntW'(1)))
    else $error("remove did not shrink the count");

endmodule

// ===== bench/tb_min_max_bag_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the min/max bag: add/remove traffic checked against a scan model.
module tb_min_max_bag_unit;

  localparam int BagDepth      = mmb_pkg::DefCapacity;
  localparam logic [mmb_pkg::OpWidth-1:0] OpUnused = 2'd3;
  localparam int GapMax        = 17;
  localparam int HoldoffAfter  = 40;
  localparam int HoldoffCycles = 400;
  // idle limit: a full-bag remove plus holdoff and stalls, taken about three times
  localparam int WatchdogLimit = 5000;
  localparam int RandomBlocks  = 14;
  localparam int BlockItems    = 40;
  localparam int MaxReports    = 10;

  typedef struct {
    logic [mmb_pkg::OpWidth-1:0]           op;
    logic signed [mmb_pkg::FieldWidth-1:0] value;
    bit                                    drain_first;
    bit                                    quiet;
  } bag_cmd_t;

  typedef struct packed {
    logic signed [mmb_pkg::FieldWidth-1:0] value;
    logic                                  was_empty;
    logic                                  add_dropped;
  } bag_result_t;

  logic clk = 1'b0;
  logic rst_n;

  mmb_in_if  in_ch ();
  mmb_out_if out_ch ();

  min_max_bag_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always #5 clk = ~clk;

  bag_cmd_t                              cmd_q[$];
  bag_result_t                           expect_q[$];
  logic signed [mmb_pkg::FieldWidth-1:0] bag_mem [BagDepth];
  int bag_cnt = 0;
  int gen_cnt = 0;
  int total_items = 0;
  int accepted_cnt = 0;
  int results_seen = 0;
  int err_cnt = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  int stall_left = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;
  bit quiet_phase = 1'b0;
  bit in_took = 1'b0;

  // Apply one accepted item to the bag copy and queue the result it must produce.
  task automatic bag_apply(input logic [mmb_pkg::OpWidth-1:0] op,
                           input logic signed [mmb_pkg::FieldWidth-1:0] val);
    bag_result_t res;
    int          best;
    res = '{value: '0, was_empty: 1'b0, add_dropped: 1'b0};
    case (op)
      mmb_pkg::OpAdd: begin
        if (bag_cnt >= BagDepth) begin
          res.add_dropped = 1'b1;
        end else begin
          bag_mem[bag_cnt] = val;
          bag_cnt++;
        end
      end
      mmb_pkg::OpRemoveMax, mmb_pkg::OpRemoveMin: begin
        if (bag_cnt == 0) begin
          res.value     = -1;
          res.was_empty = 1'b1;
        end else begin
          // strict compare keeps the lowest index on ties
          best = 0;
          for (int i = 1; i < bag_cnt; i++) begin
            if (op == mmb_pkg::OpRemoveMax ? bag_mem[i] > bag_mem[best]
                                           : bag_mem[i] < bag_mem[best]) best = i;
          end
          res.value     = bag_mem[best];
          bag_mem[best] = bag_mem[bag_cnt-1];
          bag_cnt--;
        end
      end
      default: ;
    endcase
    expect_q.push_back(res);
  endtask

  function automatic void push_cmd(input logic [mmb_pkg::OpWidth-1:0] op,
                                   input logic signed [mmb_pkg::FieldWidth-1:0] val,
                                   input bit drain_first = 1'b0,
                                   input bit quiet = 1'b0);
    cmd_q.push_back('{op: op, value: val, drain_first: drain_first, quiet: quiet});
    if (op == mmb_pkg::OpAdd && gen_cnt < BagDepth) gen_cnt++;
    else if ((op == mmb_pkg::OpRemoveMax || op == mmb_pkg::OpRemoveMin) && gen_cnt > 0)
      gen_cnt--;
  endfunction

  function automatic logic signed [mmb_pkg::FieldWidth-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return -1;
      3:       return int'($urandom_range(0, 6)) - 3;  // small values make ties
      4:       return 32'sh1 << $urandom_range(0, 31);
      5:       return ~(32'sh1 << $urandom_range(0, 31));
      default: return $urandom();
    endcase
  endfunction

  // Driver: offers queued items, holds each until taken, inserts random gaps.
  always @(negedge clk) begin
    bag_cmd_t cmd;
    if (!rst_n || !in_ch.valid || in_took) begin
      if (rst_n && gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (rst_n && cmd_q.size() != 0 &&
                   !(cmd_q[0].drain_first && expect_q.size() != 0)) begin
        cmd = cmd_q.pop_front();
        quiet_phase     <= cmd.quiet;
        in_ch.valid     <= 1'b1;
        in_ch.operation <= cmd.op;
        in_ch.value     <= cmd.value;
        if (!cmd.quiet && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, GapMax);
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts plus one long holdoff to back up the input.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (holdoff_left > 0) begin
      holdoff_left--;
      out_ch.ready <= 1'b0;
    end else if (!holdoff_done && results_seen >= HoldoffAfter) begin
      holdoff_done = 1'b1;
      holdoff_left = HoldoffCycles - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, GapMax - 1);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: predicts on input handshakes, checks output handshakes, watchdog.
  always @(posedge clk) begin
    bag_result_t got;
    bag_result_t want;
    in_took = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_took = 1'b1;
        accepted_cnt++;
        bag_apply(in_ch.operation, in_ch.value);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        got.value       = out_ch.result_value;
        got.was_empty   = out_ch.was_empty;
        got.add_dropped = out_ch.add_dropped;
        if (expect_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("unexpected result %0d: value %0d empty %0b dropped %0b",
                     results_seen, got.value, got.was_empty, got.add_dropped);
        end else begin
          want = expect_q.pop_front();
          if (got.value !== want.value || got.was_empty !== want.was_empty ||
              got.add_dropped !== want.add_dropped) begin
            err_cnt++;
            if (err_cnt <= MaxReports)
              $display("result %0d: expected value %0d empty %0b dropped %0b, %s",
                       results_seen, want.value, want.was_empty, want.add_dropped,
                       $sformatf("got value %0d empty %0b dropped %0b",
                                 got.value, got.was_empty, got.add_dropped));
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WatchdogLimit) begin
          $display("min_max_bag_unit verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    int add_pct;
    int roll;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.operation = mmb_pkg::OpAdd;
    in_ch.value     = '0;
    out_ch.ready    = 1'b0;

    // directed: empty removes, unused code, extremes, stored -1, ties
    push_cmd(mmb_pkg::OpRemoveMax, 32'sh0);
    push_cmd(mmb_pkg::OpRemoveMin, -1);
    push_cmd(OpUnused, 32'sh1234_5678);
    push_cmd(mmb_pkg::OpAdd, 32'sh7FFF_FFFF);
    push_cmd(mmb_pkg::OpAdd, 32'sh8000_0000);
    push_cmd(mmb_pkg::OpAdd, -1);
    push_cmd(mmb_pkg::OpAdd, 32'sh0);
    push_cmd(mmb_pkg::OpAdd, 32'sh5);
    push_cmd(mmb_pkg::OpAdd, 32'sh5);
    push_cmd(mmb_pkg::OpAdd, -1);
    push_cmd(mmb_pkg::OpAdd, 32'sh5555_5555);
    push_cmd(mmb_pkg::OpAdd, 32'shAAAA_AAAA);
    push_cmd(OpUnused, -1);
    push_cmd(mmb_pkg::OpRemoveMax, 32'sh0);
    push_cmd(mmb_pkg::OpRemoveMin, 32'sh0);
    push_cmd(mmb_pkg::OpRemoveMax, 32'sh0);
    push_cmd(mmb_pkg::OpRemoveMin, 32'sh0);
    push_cmd(mmb_pkg::OpRemoveMax, 32'sh0);
    push_cmd(mmb_pkg::OpRemoveMax, 32'sh0);
    push_cmd(mmb_pkg::OpRemoveMax, 32'sh0);
    push_cmd(mmb_pkg::OpRemoveMin, 32'sh0);
    push_cmd(mmb_pkg::OpRemoveMin, 32'sh0);
    push_cmd(mmb_pkg::OpRemoveMax, 32'sh0);

    // random traffic in blocks that lean toward growing or shrinking the bag
    for (int blk = 0; blk < RandomBlocks; blk++) begin
      case ($urandom_range(0, 3))
        0:       add_pct = 25;
        1:       add_pct = 50;
        2:       add_pct = 70;
        default: add_pct = 90;
      endcase
      if (gen_cnt > 300) add_pct = 20;
      for (int k = 0; k < BlockItems; k++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3)
          push_cmd(OpUnused, $urandom(), blk == 0 && k == 0);
        else if (roll < 3 + add_pct)
          push_cmd(mmb_pkg::OpAdd, pick_value(), blk == 0 && k == 0);
        else
          push_cmd($urandom_range(0, 1) ? mmb_pkg::OpRemoveMax : mmb_pkg::OpRemoveMin,
                   $urandom(), blk == 0 && k == 0);
      end
    end

    // last part, no idling: extremes and removes back to back
    push_cmd(mmb_pkg::OpAdd, pick_value(), 1'b1, 1'b1);
    push_cmd(mmb_pkg::OpAdd, 32'sh7FFF_FFFF, 1'b0, 1'b1);
    push_cmd(mmb_pkg::OpAdd, 32'sh8000_0000, 1'b0, 1'b1);
    push_cmd(mmb_pkg::OpRemoveMax, $urandom(), 1'b0, 1'b1);
    push_cmd(mmb_pkg::OpRemoveMin, $urandom(), 1'b0, 1'b1);
    push_cmd(mmb_pkg::OpAdd, pick_value(), 1'b0, 1'b1);
    push_cmd(mmb_pkg::OpAdd, pick_value(), 1'b0, 1'b1);
    push_cmd(mmb_pkg::OpAdd, pick_value(), 1'b0, 1'b1);
    push_cmd(mmb_pkg::OpRemoveMin, $urandom(), 1'b0, 1'b1);
    push_cmd(mmb_pkg::OpRemoveMax, $urandom(), 1'b0, 1'b1);
    total_items = cmd_q.size();

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    while (accepted_cnt < total_items || expect_q.size() != 0) @(posedge clk);
    // catch anything extra the longest scan could still push out
    repeat (BagDepth + 4) @(posedge clk);

    if (err_cnt == 0 && expect_q.size() == 0) begin
      $display("min_max_bag_unit verification clean");
    end else begin
      $display("min_max_bag_unit verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/mmb_pkg.sv
design/mmb_in_if.sv
design/mmb_out_if.sv
design/mmb_ram.sv
design/min_max_bag_unit.sv
bench/tb_min_max_bag_unit.sv
